[design/mv2fb_pkg.sv]
// Shared types, constants and the X.25 checksum step for the MAVLink v2 framer.
// Used by mv2fb_crc_unit and mavlink_v2_frame_builder_top; depends on nothing.
package mv2fb_pkg;

   localparam logic [7:0]  START_BYTE = 8'hFD;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;

   // Configuration register indexes (byte address / 4)
   localparam logic [1:0] REG_SYSTEM_ID     = 2'd0;
   localparam logic [1:0] REG_COMPONENT_ID  = 2'd1;
   localparam logic [1:0] REG_USE_CRC_EXTRA = 2'd2;

   // Output byte position within the framed packet
   typedef enum logic [3:0] {
      PH_START,
      PH_LEN,
      PH_INCOMPAT,
      PH_COMPAT,
      PH_SEQ,
      PH_SYSID,
      PH_COMPID,
      PH_MSGID0,
      PH_MSGID1,
      PH_MSGID2,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   // Controls into the checksum unit for one cycle
   typedef struct packed {
      logic seed;   // reload the seed (wins over folding)
      logic fold;   // fold the emitted byte
      logic extra;  // then fold the per-message extra byte
   } crc_ctrl_type;

   // One byte step of CRC-16/MCRF4XX
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

[design/mavlink_v2_frame_builder_top.sv]
// MAVLink v2 frame builder top level: input hold stage, byte sequencer, output stage, CSRs.
// Depends on mv2fb_pkg and mv2fb_crc_unit.
//
// Takes a new payload word only when the held word is done or none is held, and sends one
// framed byte per cycle while rsp_tready does not hold the output. The first word of a frame
// sends the 10 header bytes, then its payload byte; middle words send just their payload
// byte, and a word with tlast set then sends the two CRC bytes. A new word is taken in the
// same cycle the held word sends its final byte. While a byte waits on rsp_tready the
// sequencer stalls; the hold stage can still take one word if it is empty, then it
// stalls too. Header fields (length, message id) are read from the first word of a
// frame; crc_extra only from the last.
module mavlink_v2_frame_builder_top import mv2fb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // payload_byte[7:0], payload_length[15:8],
                                   // message_id[39:16], crc_extra[47:40]
   input  logic        req_tlast,  // last_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast,  // frame_end
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [7:0] system_id_ff;
   logic [7:0] component_id_ff;
   logic       use_crc_extra_ff;
   logic       csr_write;

   // Held input word
   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  payload_byte_ff;
   logic [7:0]  payload_length_ff;
   logic [23:0] message_id_ff;
   logic [7:0]  crc_extra_ff;
   logic        last_byte_ff;

   // Sequencer
   phase_type   phase_ff, phase_in;
   logic [7:0]  seq_count_ff, seq_count_in;
   logic        out_free;
   logic        emit;
   logic        item_done;
   logic        req_accept;
   logic [7:0]  emit_byte;
   logic        emit_end;
   crc_ctrl_type crc_ctrl;
   logic [15:0] crc_value;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;

   // ---------------- Configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         system_id_ff     <= 8'd1;
         component_id_ff  <= 8'd1;
         use_crc_extra_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_SYSTEM_ID:     system_id_ff     <= csr_pwdata[7:0];
            REG_COMPONENT_ID:  component_id_ff  <= csr_pwdata[7:0];
            REG_USE_CRC_EXTRA: use_crc_extra_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back selected register
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SYSTEM_ID:     csr_prdata = {24'h0, system_id_ff};
         REG_COMPONENT_ID:  csr_prdata = {24'h0, component_id_ff};
         REG_USE_CRC_EXTRA: csr_prdata = {31'h0, use_crc_extra_ff};
         default:           csr_prdata = 32'h0;
      endcase
   end

   // ---------------- Handshake control ----------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = hold_valid_ff && out_free;
   assign item_done  = emit && ((phase_ff == PH_PAYLOAD && !last_byte_ff) ||
                                phase_ff == PH_CRC_HI);
   assign req_tready = !hold_valid_ff || item_done;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      priority if (req_accept) begin
         hold_valid_in = 1'b1;
      end else if (item_done) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         payload_byte_ff   <= req_tdata[7:0];
         payload_length_ff <= req_tdata[15:8];
         message_id_ff     <= req_tdata[39:16];
         crc_extra_ff      <= req_tdata[47:40];
         last_byte_ff      <= req_tlast;
      end
   end

   // ---------------- Sequencer: next phase ----------------
   always_comb begin
      phase_in = phase_ff;
      if (emit) begin
         unique case (phase_ff)
            PH_START:    phase_in = PH_LEN;
            PH_LEN:      phase_in = PH_INCOMPAT;
            PH_INCOMPAT: phase_in = PH_COMPAT;
            PH_COMPAT:   phase_in = PH_SEQ;
            PH_SEQ:      phase_in = PH_SYSID;
            PH_SYSID:    phase_in = PH_COMPID;
            PH_COMPID:   phase_in = PH_MSGID0;
            PH_MSGID0:   phase_in = PH_MSGID1;
            PH_MSGID1:   phase_in = PH_MSGID2;
            PH_MSGID2:   phase_in = PH_PAYLOAD;
            PH_PAYLOAD:  phase_in = last_byte_ff ? PH_CRC_LO : PH_PAYLOAD;
            PH_CRC_LO:   phase_in = PH_CRC_HI;
            PH_CRC_HI:   phase_in = PH_START;
            default:     phase_in = PH_START;
         endcase
      end
   end

   // ---------------- Sequencer: outputs ----------------
   always_comb begin
      emit_end = 1'b0;
      unique case (phase_ff)
         PH_START:    emit_byte = START_BYTE;
         PH_LEN:      emit_byte = payload_length_ff;
         PH_INCOMPAT: emit_byte = 8'h00;
         PH_COMPAT:   emit_byte = 8'h00;
         PH_SEQ:      emit_byte = seq_count_ff;
         PH_SYSID:    emit_byte = system_id_ff;
         PH_COMPID:   emit_byte = component_id_ff;
         PH_MSGID0:   emit_byte = message_id_ff[7:0];
         PH_MSGID1:   emit_byte = message_id_ff[15:8];
         PH_MSGID2:   emit_byte = message_id_ff[23:16];
         PH_PAYLOAD:  emit_byte = payload_byte_ff;
         PH_CRC_LO:   emit_byte = crc_value[7:0];
         PH_CRC_HI: begin
            emit_byte = crc_value[15:8];
            emit_end  = 1'b1;
         end
         default:     emit_byte = 8'h00;
      endcase
   end

   // Checksum controls: start byte and CRC bytes are not folded
   always_comb begin
      crc_ctrl.seed  = emit && (phase_ff == PH_START || phase_ff == PH_CRC_HI);
      crc_ctrl.fold  = emit && phase_ff != PH_START && phase_ff != PH_CRC_LO &&
                       phase_ff != PH_CRC_HI;
      crc_ctrl.extra = emit && phase_ff == PH_PAYLOAD && last_byte_ff && use_crc_extra_ff;
   end

   mv2fb_crc_unit u_crc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (crc_ctrl),
      .data_byte  (emit_byte),
      .extra_byte (crc_extra_ff),
      .crc        (crc_value)
   );

   // Advance sequence count once per header
   assign seq_count_in = (emit && phase_ff == PH_SEQ) ? seq_count_ff + 8'd1 : seq_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_START;
         seq_count_ff  <= 8'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         seq_count_ff  <= seq_count_in;
      end
   end

   // ---------------- Output register ----------------
   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_end_ff  <= emit_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_end_ff;

   // ---------------- Assertions ----------------
   // With no word held, the sequencer rests between frames or inside a payload
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> (phase_ff == PH_START || phase_ff == PH_PAYLOAD))
      else $error("sequencer idle in the middle of a header or CRC");

   // Sequence count moves exactly when the sequence byte goes out
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (emit && phase_ff == PH_SEQ) |=> seq_count_ff == $past(seq_count_ff) + 8'd1)
      else $error("sequence count did not advance with header");

   // The high CRC byte goes out marked as frame end
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (emit && phase_ff == PH_CRC_HI) |=> (rsp_tvalid && rsp_tlast))
      else $error("frame end missing on high CRC byte");

endmodule

[design/mv2fb_crc_unit.sv]
// Running X.25 checksum register for the MAVLink v2 framer.
// Depends on mv2fb_pkg for crc_fold, CRC_SEED and crc_ctrl_type.
module mv2fb_crc_unit import mv2fb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   input  logic [7:0]   data_byte,
   input  logic [7:0]   extra_byte,
   output logic [15:0]  crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] crc_byte;
   logic [15:0] crc_extra;

   // Fold the emitted byte, then optionally the extra byte
   always_comb begin
      crc_byte  = ctrl.fold  ? crc_fold(crc_ff, data_byte)    : crc_ff;
      crc_extra = ctrl.extra ? crc_fold(crc_byte, extra_byte) : crc_byte;
      crc_in    = ctrl.seed  ? CRC_SEED : crc_extra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_extra;

endmodule

[verif/tb_top.sv]
// Self-checking bench for mavlink_v2_frame_builder_top: streams payload words, predicts every
// framed byte (header, payload, X.25 checksum) and compares field by field.
// Depends on mv2fb_pkg and the design files under design/.
module tb_top;
   import mv2fb_pkg::*;

   localparam int MAX_WAIT      = 18;
   localparam int STALL_LIMIT   = 2000;   // cycles with no word moving on either side
   localparam int SETTLE_CYCLES = 20;
   localparam int WORDS_WANTED  = 400;
   localparam int FRAMES_WANTED = 260;    // enough frames to wrap the sequence count
   localparam int BATCH_FRAMES  = 40;

   localparam logic [1:0]  REG_UNMAPPED   = 2'd3;
   localparam logic [7:0]  INCOMPAT_FLAGS = 8'h00;
   localparam logic [7:0]  COMPAT_FLAGS   = 8'h00;
   localparam logic [15:0] X25_POLY_REFL  = 16'h8408;

   // One payload word as it travels on tlast and tdata (payload byte in the low bits)
   typedef struct packed {
      logic        last;
      logic [7:0]  extra;
      logic [23:0] msg_id;
      logic [7:0]  length;
      logic [7:0]  payload;
   } payload_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
   } framed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // payload_byte[7:0], payload_length[15:8],
                                  // message_id[39:16], crc_extra[47:40]
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte[7:0]
   logic        rsp_tlast;        // frame_end
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Stimulus and expected bytes
   payload_word_type words_pending[$];
   framed_byte_type  frame_bytes_due[$];

   // Predictor copy of the registers and framer state
   logic [7:0]  cfg_system_id = 8'd1;
   logic [7:0]  cfg_component_id = 8'd1;
   logic        cfg_crc_extra = 1'b0;
   logic [7:0]  model_seq = '0;
   logic [15:0] model_crc = CRC_SEED;
   logic        model_in_frame = 1'b0;

   bit req_taken, rsp_taken;
   bit req_idle_on, rsp_idle_on;
   int req_gap, rsp_hold;
   int idle_cycles, failures;
   int words_queued, frames_queued, words_accepted, frames_accepted;
   int bytes_checked, seq_wraps, settings_used;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   mavlink_v2_frame_builder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Reflected-polynomial form of the X.25 checksum, one bit at a time
   function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ X25_POLY_REFL) : (c >> 1);
      return c;
   endfunction

   function automatic int draw_wait(input bit enabled);
      if (!enabled || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic expect_byte(input logic [7:0] b, input logic eof, input logic fold);
      framed_byte_type fb;
      fb.data = b;
      fb.eof  = eof;
      frame_bytes_due = {frame_bytes_due, fb};
      if (fold)
         model_crc = x25_update(model_crc, b);
   endtask

   // Predict the framed bytes caused by one accepted payload word
   task automatic frame_payload_word(input payload_word_type w);
      if (!model_in_frame) begin
         model_crc = CRC_SEED;
         expect_byte(START_BYTE, 1'b0, 1'b0);
         expect_byte(w.length, 1'b0, 1'b1);
         expect_byte(INCOMPAT_FLAGS, 1'b0, 1'b1);
         expect_byte(COMPAT_FLAGS, 1'b0, 1'b1);
         expect_byte(model_seq, 1'b0, 1'b1);
         expect_byte(cfg_system_id, 1'b0, 1'b1);
         expect_byte(cfg_component_id, 1'b0, 1'b1);
         expect_byte(w.msg_id[7:0], 1'b0, 1'b1);
         expect_byte(w.msg_id[15:8], 1'b0, 1'b1);
         expect_byte(w.msg_id[23:16], 1'b0, 1'b1);
         model_seq = model_seq + 8'd1;
         if (model_seq == 8'd0)
            seq_wraps++;
         model_in_frame = 1'b1;
      end
      expect_byte(w.payload, 1'b0, 1'b1);
      // Close the frame: optional extra byte, then checksum low and high
      if (w.last) begin
         if (cfg_crc_extra)
            model_crc = x25_update(model_crc, w.extra);
         expect_byte(model_crc[7:0], 1'b0, 1'b0);
         expect_byte(model_crc[15:8], 1'b1, 1'b0);
         model_crc = CRC_SEED;
         model_in_frame = 1'b0;
      end
   endtask

   task automatic queue_word(input logic [7:0] payload, input logic [7:0] length,
                             input logic [23:0] msg_id, input logic [7:0] extra,
                             input logic last);
      payload_word_type w;
      w.payload = payload;
      w.length  = length;
      w.msg_id  = msg_id;
      w.extra   = extra;
      w.last    = last;
      words_pending = {words_pending, w};
      words_queued++;
      if (last)
         frames_queued++;
   endtask

   // Mostly single-word frames so the sequence count wraps; a few long ones
   task automatic queue_random_frame();
      int sel, n;
      logic [7:0] len;
      logic [23:0] id;
      sel = $urandom_range(0, 99);
      if (sel < 92)
         n = 1;
      else if (sel < 99)
         n = $urandom_range(2, 6);
      else
         n = $urandom_range(7, 30);
      len = ($urandom_range(0, 9) < 7) ? n[7:0] : 8'($urandom_range(0, 255));
      id = 24'($urandom);
      // later words carry random header fields that must be ignored
      for (int k = 0; k < n; k++)
         queue_word(8'($urandom_range(0, 255)), (k == 0) ? len : 8'($urandom_range(0, 255)),
                    (k == 0) ? id : 24'($urandom), 8'($urandom_range(0, 255)), k == n - 1);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_SYSTEM_ID:     cfg_system_id = value[7:0];
         REG_COMPONENT_ID:  cfg_component_id = value[7:0];
         REG_USE_CRC_EXTRA: cfg_crc_extra = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] sys, input logic [31:0] comp,
                            input logic [31:0] extra);
      write_reg(REG_SYSTEM_ID, sys);
      write_reg(REG_COMPONENT_ID, comp);
      write_reg(REG_USE_CRC_EXTRA, extra);
      settings_used++;
   endtask

   // Hold until every word is taken and every framed byte has come back
   task automatic wait_drained();
      while (words_pending.size() != 0 || req_tvalid || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input driver: hold a word until taken, then wait out its drawn gap
   always @(negedge clock) begin : req_driver
      bit took;
      payload_word_type w;
      took = req_taken;
      req_taken = 1'b0;
      if (took)
         req_gap = draw_wait(req_idle_on);
      if (reset || (req_tvalid && !took)) begin
         // hold
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap--;
      end else if (words_pending.size() != 0) begin
         w = words_pending.pop_front();
         req_tdata  <= w[47:0];
         req_tlast  <= w.last;
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result side: stall a drawn number of cycles after each byte
   always @(negedge clock) begin : rsp_driver
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_hold = draw_wait(rsp_idle_on);
      end
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: check framed bytes, predict from accepted words, watch for a hang
   always @(posedge clock) begin : monitor
      framed_byte_type want;
      payload_word_type w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            bytes_checked++;
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected framed byte %02h (frame_end %0b)", rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.eof) begin
                  $error("frame_end: expected %0b, got %0b", want.eof, rsp_tlast);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            w = {req_tlast, req_tdata};
            words_accepted++;
            if (w.last)
               frames_accepted++;
            frame_payload_word(w);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Hang: no word moved for %0d cycles, %0d bytes still due",
                     STALL_LIMIT, frame_bytes_due.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings, no idling: extremes, zero length, length mismatch
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      settings_used = 1;
      queue_word(8'h00, 8'h00, 24'h000000, 8'h00, 1'b1);
      queue_word(8'hFF, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b1);
      queue_word(8'h55, 8'h0A, 24'h123456, 8'hAA, 1'b0);
      queue_word(8'hAA, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b0);
      queue_word(8'h01, 8'h00, 24'h000000, 8'h80, 1'b1);
      queue_word(8'h80, 8'h04, 24'h800001, 8'h11, 1'b0);
      queue_word(8'h7F, 8'h01, 24'h7FFFFE, 8'h22, 1'b0);
      queue_word(8'hC3, 8'h02, 24'h00FF00, 8'h33, 1'b0);
      queue_word(8'h3C, 8'h03, 24'hFF00FF, 8'h44, 1'b1);
      wait_drained();

      // Extra byte folded in; sender idles only
      configure(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      req_idle_on = 1'b1;
      queue_word(8'h7E, 8'h01, 24'h000000, 8'hFF, 1'b1);
      queue_word(8'h81, 8'h01, 24'hFFFFFF, 8'h00, 1'b1);
      queue_word(8'h10, 8'h02, 24'h00004C, 8'hFF, 1'b0);
      queue_word(8'h20, 8'h02, 24'h00004C, 8'h5A, 1'b1);
      repeat (BATCH_FRAMES) queue_random_frame();
      wait_drained();

      // Opposite extremes, plus a write to an unmapped register; receiver stalls only
      configure(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFE);
      write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      repeat (BATCH_FRAMES) queue_random_frame();
      wait_drained();

      // Random settings and idling mixes until enough words and frames have gone
      phase = 0;
      while (words_queued < WORDS_WANTED || frames_queued < FRAMES_WANTED) begin
         configure($urandom, $urandom, $urandom);
         req_idle_on = phase[0];
         rsp_idle_on = phase[1];
         repeat (BATCH_FRAMES) queue_random_frame();
         wait_drained();
         phase++;
      end

      $display("Framed %0d payload words in %0d frames and checked %0d output bytes",
               words_accepted, frames_accepted, bytes_checked);
      $display("Covered %0d register settings and %0d sequence wraps",
               settings_used, seq_wraps);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
